### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/ima_pkg.sv
package ima_pkg;

  localparam int unsigned DefaultMaxDim = 8;
  localparam int unsigned DataW         = 32;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned DimW          = 4;
  localparam int unsigned CmdW          = 3;
  localparam int unsigned PaddrW        = 4;
  localparam int unsigned PdataW        = 32;

  typedef enum logic [CmdW-1:0] {
    CmdLoadA = 3'd0,
    CmdLoadB = 3'd1,
    CmdAdd   = 3'd2,
    CmdSub   = 3'd3,
    CmdMul   = 3'd4,
    CmdTrans = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    RegRowsA = 2'd0,
    RegColsA = 2'd1,
    RegRowsB = 2'd2,
    RegColsB = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            valid;
    cmd_e            op;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            first;
    logic            last_k;
    logic            last;
    logic            err;
  } tag_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v,
                                                logic [DimW-1:0] max_dim);
    logic [DimW-1:0] r;
    r = v;
    if (r == '0) r = DimW'(1);
    if (r > max_dim) r = max_dim;
    return r;
  endfunction

endpackage

### design/ima_if.sv
interface ima_in_if;
  logic                            valid;
  logic                            ready;
  logic [ima_pkg::CmdW-1:0]        cmd;
  logic [ima_pkg::IdxW-1:0]        row_index;
  logic [ima_pkg::IdxW-1:0]        col_index;
  logic signed [ima_pkg::DataW-1:0] element_value;

  modport source(output valid, cmd, row_index, col_index, element_value, input ready);
  modport sink(input valid, cmd, row_index, col_index, element_value, output ready);
endinterface

interface ima_out_if;
  logic                            valid;
  logic                            ready;
  logic [ima_pkg::IdxW-1:0]        out_row;
  logic [ima_pkg::IdxW-1:0]        out_col;
  logic signed [ima_pkg::DataW-1:0] out_value;
  logic                            last;
  logic                            size_error;

  modport source(output valid, out_row, out_col, out_value, last, size_error, input ready);
  modport sink(input valid, out_row, out_col, out_value, last, size_error, output ready);
endinterface

### design/ima_mac.sv
module ima_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ima_pkg::tag_t             tag_i,
  input  logic [ima_pkg::DataW-1:0] a_i,
  input  logic [ima_pkg::DataW-1:0] b_i,
  output logic                      adv_o,
  ima_out_if.source                 out_ch
);

  ima_pkg::tag_t             tag2_q;
  logic [ima_pkg::DataW-1:0] val_d, val_q;
  logic [ima_pkg::DataW-1:0] acc_q, sum;
  logic                      out_valid_q;
  logic [ima_pkg::IdxW-1:0]  out_row_q, out_col_q;
  logic [ima_pkg::DataW-1:0] out_value_q;
  logic                      out_last_q, out_err_q;

  assign adv_o = !out_valid_q || out_ch.ready;

  always_comb begin
    unique case (tag_i.op)
      ima_pkg::CmdAdd: val_d = a_i + b_i;
      ima_pkg::CmdSub: val_d = a_i - b_i;
      ima_pkg::CmdMul: val_d = a_i * b_i;
      default:         val_d = a_i;
    endcase
    if (tag_i.err) val_d = '0;
  end

  assign sum = (tag2_q.first ? '0 : acc_q) + val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      tag2_q      <= tag_i;
      out_valid_q <= tag2_q.valid && tag2_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      val_q <= val_d;
      if (tag2_q.valid) acc_q <= sum;
      if (tag2_q.valid && tag2_q.last_k) begin
        out_row_q   <= tag2_q.row;
        out_col_q   <= tag2_q.col;
        out_value_q <= sum;
        out_last_q  <= tag2_q.last;
        out_err_q   <= tag2_q.err;
      end
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.out_row    = out_row_q;
  assign out_ch.out_col    = out_col_q;
  assign out_ch.out_value  = out_value_q;
  assign out_ch.last       = out_last_q;
  assign out_ch.size_error = out_err_q;

endmodule

### design/integer_matrix_arithmetic.sv
// Matrix unit holding A and B (up to MAX_DIM x MAX_DIM 32-bit elements) in two
// memories with a write port and a registered read port. A load item writes
// one element if both indices are below MAX_DIM; it gives no result. A run
// item starts a sequencer that issues one read of each memory per cycle unless
// the output stalls: add, subtract and transpose read once per result element,
// multiply reads cols_a times per element (one product per read, summed in an
// accumulator), so a run issues rows*cols, or rows_a*cols_b*cols_a, reads. A
// size mismatch issues a single read and gives one error item. The next input
// item is taken the cycle after the last read of a run is issued; results pass
// through the read data, operation and output registers, waiting in the last.
module integer_matrix_arithmetic #(
  parameter int unsigned MAX_DIM = ima_pkg::DefaultMaxDim
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ima_in_if.sink                      in_ch,
  ima_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ima_pkg::PaddrW-1:0]  paddr,
  input  logic [ima_pkg::PdataW-1:0]  pwdata,
  output logic [ima_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [ima_pkg::DimW-1:0] MaxDim = ima_pkg::DimW'(MAX_DIM);
  localparam logic [ima_pkg::DimW-1:0] One    = ima_pkg::DimW'(1);

  function automatic logic [AddrW-1:0] addr_of(logic [ima_pkg::IdxW-1:0] r,
                                               logic [ima_pkg::IdxW-1:0] c);
    return AddrW'(r * MAX_DIM + c);
  endfunction

  logic [ima_pkg::DimW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic                     cfg_wr;
  logic [ima_pkg::DimW-1:0] cfg_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_val = ima_pkg::clamp_dim(pwdata[ima_pkg::DimW-1:0], MaxDim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= ima_pkg::clamp_dim(ima_pkg::DimW'(8), MaxDim);
      cols_a_q <= ima_pkg::clamp_dim(ima_pkg::DimW'(8), MaxDim);
      rows_b_q <= ima_pkg::clamp_dim(ima_pkg::DimW'(8), MaxDim);
      cols_b_q <= ima_pkg::clamp_dim(ima_pkg::DimW'(8), MaxDim);
    end else if (cfg_wr) begin
      unique case (ima_pkg::cfg_reg_e'(paddr[3:2]))
        ima_pkg::RegRowsA: rows_a_q <= cfg_val;
        ima_pkg::RegColsA: cols_a_q <= cfg_val;
        ima_pkg::RegRowsB: rows_b_q <= cfg_val;
        ima_pkg::RegColsB: cols_b_q <= cfg_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ima_pkg::cfg_reg_e'(paddr[3:2]))
      ima_pkg::RegRowsA: prdata = ima_pkg::PdataW'(rows_a_q);
      ima_pkg::RegColsA: prdata = ima_pkg::PdataW'(cols_a_q);
      ima_pkg::RegRowsB: prdata = ima_pkg::PdataW'(rows_b_q);
      ima_pkg::RegColsB: prdata = ima_pkg::PdataW'(cols_b_q);
      default:           prdata = '0;
    endcase
  end

  logic                     busy_q, err_q;
  ima_pkg::cmd_e            op_q;
  logic [ima_pkg::DimW-1:0] nr_q, nc_q, kn_q;
  logic [ima_pkg::IdxW-1:0] i_q, j_q, k_q;
  logic                     in_acc, is_run, wr_ok, adv;
  ima_pkg::cmd_e            cmd_in;
  logic [ima_pkg::DimW-1:0] nr_d, nc_d, kn_d;
  logic                     err_d;
  logic                     i_end, j_end, k_end;
  ima_pkg::tag_t            tag_s, tag1_q;
  logic [AddrW-1:0]         wr_addr, rd_a_addr, rd_b_addr;
  logic [ima_pkg::DataW-1:0] mem_a [Depth];
  logic [ima_pkg::DataW-1:0] mem_b [Depth];
  logic [ima_pkg::DataW-1:0] rd_a_q, rd_b_q;

  assign in_ch.ready = !busy_q;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cmd_in      = ima_pkg::cmd_e'(in_ch.cmd);
  assign wr_ok       = ({1'b0, in_ch.row_index} < MaxDim) && ({1'b0, in_ch.col_index} < MaxDim);
  assign wr_addr     = addr_of(in_ch.row_index, in_ch.col_index);

  always_comb begin
    is_run = 1'b1;
    err_d  = 1'b0;
    nr_d   = rows_a_q;
    nc_d   = cols_a_q;
    kn_d   = One;
    unique case (cmd_in)
      ima_pkg::CmdMul: begin
        nc_d  = cols_b_q;
        kn_d  = cols_a_q;
        err_d = cols_a_q != rows_b_q;
      end
      ima_pkg::CmdTrans: begin
        nr_d = cols_a_q;
        nc_d = rows_a_q;
      end
      ima_pkg::CmdAdd, ima_pkg::CmdSub: begin
        err_d = (rows_a_q != rows_b_q) || (cols_a_q != cols_b_q);
      end
      default: is_run = 1'b0;
    endcase
    if (err_d) begin
      nr_d = One;
      nc_d = One;
      kn_d = One;
    end
  end

  assign i_end = {1'b0, i_q} == nr_q - One;
  assign j_end = {1'b0, j_q} == nc_q - One;
  assign k_end = {1'b0, k_q} == kn_q - One;

  always_comb begin
    tag_s.valid  = busy_q;
    tag_s.op     = op_q;
    tag_s.row    = i_q;
    tag_s.col    = j_q;
    tag_s.first  = k_q == '0;
    tag_s.last_k = k_end;
    tag_s.last   = i_end && j_end && k_end;
    tag_s.err    = err_q;
  end

  always_comb begin
    unique case (op_q)
      ima_pkg::CmdMul: begin
        rd_a_addr = addr_of(i_q, k_q);
        rd_b_addr = addr_of(k_q, j_q);
      end
      ima_pkg::CmdTrans: begin
        rd_a_addr = addr_of(j_q, i_q);
        rd_b_addr = addr_of(i_q, j_q);
      end
      default: begin
        rd_a_addr = addr_of(i_q, j_q);
        rd_b_addr = addr_of(i_q, j_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tag1_q <= '0;
    end else begin
      if (adv) tag1_q <= tag_s;
      if (in_acc && is_run) begin
        busy_q <= 1'b1;
      end else if (busy_q && adv && tag_s.last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_run) begin
      op_q  <= cmd_in;
      err_q <= err_d;
      nr_q  <= nr_d;
      nc_q  <= nc_d;
      kn_q  <= kn_d;
      i_q   <= '0;
      j_q   <= '0;
      k_q   <= '0;
    end else if (busy_q && adv) begin
      if (k_end) begin
        k_q <= '0;
        if (j_end) begin
          j_q <= '0;
          i_q <= i_q + ima_pkg::IdxW'(1);
        end else begin
          j_q <= j_q + ima_pkg::IdxW'(1);
        end
      end else begin
        k_q <= k_q + ima_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_ok && cmd_in == ima_pkg::CmdLoadA) mem_a[wr_addr] <= in_ch.element_value;
    if (adv) rd_a_q <= mem_a[rd_a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_ok && cmd_in == ima_pkg::CmdLoadB) mem_b[wr_addr] <= in_ch.element_value;
    if (adv) rd_b_q <= mem_b[rd_b_addr];
  end

  ima_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag1_q),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .adv_o  (adv),
    .out_ch (out_ch)
  );

endmodule

### design/ima_checker.sv
`include "assert_macros.svh"

module ima_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ima_pkg::IdxW-1:0]    out_row,
  input logic [ima_pkg::IdxW-1:0]    out_col,
  input logic [ima_pkg::DataW-1:0]   out_value,
  input logic                        last,
  input logic                        size_error
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_err_last, out_valid && size_error, last)
  `ASSERT_IMPL(a_err_zero, out_valid && size_error, out_row == '0 && out_col == '0 && out_value == '0)

endmodule

bind integer_matrix_arithmetic ima_checker u_ima_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_row    (out_ch.out_row),
  .out_col    (out_ch.out_col),
  .out_value  (out_ch.out_value),
  .last       (out_ch.last),
  .size_error (out_ch.size_error)
);
